[src/mlp_pkg.sv]
// Shared types and constants of the median, low-pass and PID speed loop.
`default_nettype none

package mlp_pkg;

  // Configuration port.
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P = 3'd0,
    CFG_GAIN_I = 3'd1,
    CFG_GAIN_D = 3'd2,
    CFG_TARGET = 3'd3,
    CFG_ALPHA  = 3'd4,
    CFG_LIMIT  = 3'd5
  } cfg_idx_e;

  // Register reset values.
  localparam logic signed [31:0] GAIN_P_RST = 32'sd8388608;
  localparam logic signed [31:0] GAIN_I_RST = 32'sd0;
  localparam logic signed [31:0] GAIN_D_RST = 32'sd1678;
  localparam logic signed [31:0] TARGET_RST = 32'sd32768000;
  localparam logic [16:0] ALPHA_RST = 17'd6554;
  localparam logic [30:0] LIMIT_RST = 31'd196608;

  // Arithmetic constants.
  localparam logic [16:0] ALPHA_ONE = 17'd65536;
  localparam logic signed [65:0] ROUND_HALF = 66'sd32768;
  localparam logic [47:0] ONE_MILLION = 48'd1000000;
  localparam logic signed [32:0] MILLION_S = 33'sd1000000;
  localparam logic [47:0] DT_DEFAULT = 48'd1000;
  localparam logic [48:0] TERM_CAP = 49'h1_0000_0000_0000;
  localparam int unsigned SUM_W = 52;

  // Shared divider geometry.
  localparam int unsigned DIV_NUM_W = 54;
  localparam int unsigned DIV_DEN_W = 48;

  // Step index carried with each command.
  localparam int unsigned IDX_W = 4;
  localparam logic [IDX_W-1:0] TERM_ERR = 4'd0;
  localparam logic [IDX_W-1:0] TERM_INT = 4'd1;
  localparam logic [IDX_W-1:0] TERM_DER = 4'd2;

  // Datapath operations.
  typedef enum logic [4:0] {
    OP_NONE, OP_MED, OP_F1, OP_F2, OP_F3, OP_ERR, OP_QR, OP_M1, OP_M2, OP_M3,
    OP_INTEG, OP_D1, OP_D2, OP_DERIV, OP_G0, OP_G1, OP_G2, OP_G3
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] idx;
    logic             load;
    logic             out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

[src/mlp_ifs.sv]
// Input and output channel interfaces of the speed loop.
`default_nettype none

interface mlp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] speed_sample;
  logic        [47:0] timestamp_us;

  modport source (output valid, output speed_sample, output timestamp_us, input ready);
  modport sink (input valid, input speed_sample, input timestamp_us, output ready);
endinterface

interface mlp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive;
  logic signed [31:0] filtered_speed;

  modport source (output valid, output drive, output filtered_speed, input ready);
  modport sink (input valid, input drive, input filtered_speed, output ready);
endinterface

`default_nettype wire

[src/mlp_div.sv]
// Iterative unsigned divider, two quotient bits per cycle.
`default_nettype none

module mlp_div #(
  parameter int unsigned NUM_W = 54,
  parameter int unsigned DEN_W = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quo_o,
  output logic [DEN_W-1:0] rem_o
);

  localparam int unsigned STEPS = NUM_W / 2;
  localparam int unsigned CNT_W = $clog2(STEPS + 1);

  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;

  // Two restoring steps: shift in a numerator bit, subtract when it fits.
  always_comb begin
    logic [DEN_W:0] trial;
    num_d = num_q;
    rem_d = rem_q;
    for (int s = 0; s < 2; s++) begin
      trial = {rem_d, num_d[NUM_W-1]};
      if (trial >= {1'b0, den_q}) begin
        trial = trial - {1'b0, den_q};
        num_d = {num_d[NUM_W-2:0], 1'b1};
      end else begin
        num_d = {num_d[NUM_W-2:0], 1'b0};
      end
      rem_d = trial[DEN_W-1:0];
    end
  end

  // Control of the iteration count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(STEPS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = num_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

[src/mlp_dp.sv]
// Datapath: window, median search, low-pass, PID arithmetic and config registers.
`default_nettype none

module mlp_dp #(
  parameter int unsigned WINDOW_LEN = 5
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mlp_pkg::dp_cmd_t               cmd_i,
  output mlp_pkg::dp_stat_t              stat_o,
  input  logic                           cfg_we_i,
  input  logic [mlp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mlp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic signed [31:0]             speed_sample_i,
  input  logic [47:0]                    timestamp_us_i,
  output logic signed [31:0]             drive_o,
  output logic signed [31:0]             filtered_speed_o
);

  import mlp_pkg::*;

  localparam int unsigned MIDX_W = $clog2(WINDOW_LEN);
  localparam int unsigned CNT_W = $clog2(WINDOW_LEN + 1);
  localparam logic [CNT_W-1:0] WIN_FULL = CNT_W'(WINDOW_LEN);
  localparam logic [CNT_W-1:0] MID_RANK = CNT_W'(WINDOW_LEN / 2);

  // Configuration registers.
  logic signed [31:0] gain_p_q, gain_i_q, gain_d_q, target_q;
  logic [16:0]        alpha_q;
  logic [30:0]        limit_q;

  // Loop state.
  logic signed [31:0] win_q [WINDOW_LEN];
  logic [CNT_W-1:0]   fill_q;
  logic signed [31:0] med_q, filt_q, perr_q;
  logic signed [63:0] integ_q;
  logic [47:0]        pts_q;

  // Working registers.
  logic [47:0]        dt_q;
  logic signed [31:0] err_q;
  logic [28:0]        q_q;
  logic [19:0]        r_q;
  logic signed [65:0] mult_q, acc_q;
  logic [63:0]        lo_q, amag_q;
  logic [31:0]        gmag_q;
  logic               neg_q, dsign_q;
  logic signed [63:0] deriv_q;
  logic signed [SUM_W-1:0] sum_q;
  logic signed [31:0] out_drive_q, out_filt_q;

  // Divider hookup.
  logic                 div_start, div_busy;
  logic [DIV_NUM_W-1:0] div_num, div_quo;
  logic [DIV_DEN_W-1:0] div_den, div_rem;

  mlp_div #(
    .NUM_W(DIV_NUM_W),
    .DEN_W(DIV_DEN_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .quo_o  (div_quo),
    .rem_o  (div_rem)
  );

  assign stat_o.div_busy = div_busy;

  // Rank of the current median candidate within the window.
  logic signed [31:0] cand;
  logic [CNT_W-1:0]   less_cnt, eq_cnt;
  logic               is_med;

  always_comb begin
    cand = win_q[cmd_i.idx[MIDX_W-1:0]];
    less_cnt = '0;
    eq_cnt = '0;
    for (int j = 0; j < WINDOW_LEN; j++) begin
      less_cnt = less_cnt + CNT_W'(win_q[j] < cand);
      eq_cnt = eq_cnt + CNT_W'(win_q[j] == cand);
    end
    is_med = (less_cnt <= MID_RANK) && (MID_RANK < less_cnt + eq_cnt);
  end

  // Shared multiplier operand selection.
  logic [16:0]        alpha_c;
  logic signed [32:0] err_diff, ma, mb;
  logic signed [65:0] mprod;
  logic [65:0]        mult_abs;

  assign alpha_c  = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
  assign err_diff = {err_q[31], err_q} - {perr_q[31], perr_q};
  assign mult_abs = mult_q[65] ? 66'(-mult_q) : 66'(mult_q);

  always_comb begin
    case (cmd_i.op)
      OP_F1: begin
        ma = $signed({16'd0, alpha_c});
        mb = {med_q[31], med_q};
      end
      OP_F2: begin
        ma = $signed({16'd0, 17'(ALPHA_ONE - alpha_c)});
        mb = {filt_q[31], filt_q};
      end
      OP_M1: begin
        ma = {err_q[31], err_q};
        mb = $signed({4'd0, q_q});
      end
      OP_M2: begin
        ma = {err_q[31], err_q};
        mb = $signed({13'd0, r_q});
      end
      OP_D1: begin
        ma = err_diff;
        mb = MILLION_S;
      end
      OP_G1: begin
        ma = $signed({1'b0, amag_q[31:0]});
        mb = $signed({1'b0, gmag_q});
      end
      OP_G2: begin
        ma = $signed({1'b0, amag_q[63:32]});
        mb = $signed({1'b0, gmag_q});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    mprod = ma * mb;
  end

  // Divider launch: seconds split of dt, integral fraction, derivative.
  always_comb begin
    div_start = 1'b0;
    div_num = mult_abs[DIV_NUM_W-1:0];
    div_den = ONE_MILLION;
    case (cmd_i.op)
      OP_ERR: begin
        div_start = 1'b1;
        div_num = DIV_NUM_W'(dt_q);
      end
      OP_M3: div_start = 1'b1;
      OP_D2: begin
        div_start = 1'b1;
        div_den = dt_q;
      end
      default: div_start = 1'b0;
    endcase
  end

  // Signed quotient, saturated integral update, filter sum and saturated error.
  logic signed [63:0] quo_s, incr;
  logic signed [64:0] isum;
  logic signed [63:0] integ_next;
  logic signed [65:0] fsum;
  logic signed [32:0] ediff;
  logic signed [31:0] err_sat;

  always_comb begin
    quo_s = dsign_q ? -$signed(64'(div_quo)) : $signed(64'(div_quo));
    incr = acc_q[63:0] + quo_s;
    isum = {integ_q[63], integ_q} + {incr[63], incr};
    if (isum[64] != isum[63]) begin
      integ_next = isum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      integ_next = isum[63:0];
    end
    fsum = acc_q + mult_q;
    ediff = {target_q[31], target_q} - {filt_q[31], filt_q};
    if (ediff[32] != ediff[31]) begin
      err_sat = ediff[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else begin
      err_sat = ediff[31:0];
    end
  end

  // Gain term operand and finished term.
  logic signed [63:0] top_a;
  logic signed [31:0] top_g;
  logic [48:0]        term_m;
  logic signed [SUM_W-1:0] term_s, sum_base;

  always_comb begin
    case (cmd_i.idx)
      TERM_ERR: begin
        top_a = {{32{err_q[31]}}, err_q};
        top_g = gain_p_q;
      end
      TERM_INT: begin
        top_a = integ_q;
        top_g = gain_i_q;
      end
      default: begin
        top_a = deriv_q;
        top_g = gain_d_q;
      end
    endcase
    if (mult_q[65:40] != '0) begin
      term_m = TERM_CAP;
    end else begin
      term_m = {1'b0, mult_q[39:0], 8'd0} + {9'd0, lo_q[63:24]};
      if (term_m > TERM_CAP) begin
        term_m = TERM_CAP;
      end
    end
    term_s = neg_q ? -$signed(SUM_W'(term_m)) : $signed(SUM_W'(term_m));
    sum_base = (cmd_i.idx == TERM_ERR) ? '0 : sum_q;
  end

  // Output clamp.
  logic signed [SUM_W-1:0] lim_s;
  logic signed [31:0]      drive_c;

  always_comb begin
    lim_s = $signed(SUM_W'(limit_q));
    if (sum_q > lim_s) begin
      drive_c = lim_s[31:0];
    end else if (sum_q < -lim_s) begin
      drive_c = 32'(-lim_s);
    end else begin
      drive_c = sum_q[31:0];
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= GAIN_P_RST;
      gain_i_q <= GAIN_I_RST;
      gain_d_q <= GAIN_D_RST;
      target_q <= TARGET_RST;
      alpha_q  <= ALPHA_RST;
      limit_q  <= LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_GAIN_P: gain_p_q <= $signed(cfg_data_i);
        CFG_GAIN_I: gain_i_q <= $signed(cfg_data_i);
        CFG_GAIN_D: gain_d_q <= $signed(cfg_data_i);
        CFG_TARGET: target_q <= $signed(cfg_data_i);
        CFG_ALPHA:  alpha_q  <= cfg_data_i[16:0];
        CFG_LIMIT:  limit_q  <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Loop state that survives from word to word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      med_q   <= '0;
      filt_q  <= '0;
      integ_q <= '0;
      perr_q  <= '0;
      pts_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        pts_q <= timestamp_us_i;
        if (fill_q != WIN_FULL) begin
          fill_q <= fill_q + 1'b1;
        end
      end
      if (cmd_i.op == OP_MED && fill_q == WIN_FULL && is_med) begin
        med_q <= cand;
      end
      if (cmd_i.op == OP_F3) begin
        filt_q <= fsum[47:16];
      end
      if (cmd_i.op == OP_INTEG) begin
        integ_q <= integ_next;
      end
      if (cmd_i.op == OP_DERIV) begin
        perr_q <= err_q;
      end
    end
  end

  // Window shift, per-word working registers and output registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < WINDOW_LEN - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WINDOW_LEN-1] <= speed_sample_i;
      dt_q <= (timestamp_us_i > pts_q) ? (timestamp_us_i - pts_q) : DT_DEFAULT;
    end
    case (cmd_i.op)
      OP_F1: mult_q <= mprod;
      OP_F2: begin
        acc_q  <= mult_q + ROUND_HALF;
        mult_q <= mprod;
      end
      OP_ERR: err_q <= err_sat;
      OP_QR: begin
        q_q <= div_quo[28:0];
        r_q <= div_rem[19:0];
      end
      OP_M1: mult_q <= mprod;
      OP_M2: begin
        acc_q  <= mult_q;
        mult_q <= mprod;
      end
      OP_M3, OP_D2: dsign_q <= mult_q[65];
      OP_D1: mult_q <= mprod;
      OP_DERIV: deriv_q <= quo_s;
      OP_G0: begin
        amag_q <= top_a[63] ? 64'(-top_a) : 64'(top_a);
        gmag_q <= top_g[31] ? 32'(-top_g) : 32'(top_g);
        neg_q  <= top_a[63] ^ top_g[31];
      end
      OP_G1: mult_q <= mprod;
      OP_G2: begin
        lo_q   <= mult_q[63:0];
        mult_q <= mprod;
      end
      OP_G3: sum_q <= sum_base + term_s;
      default: ;
    endcase
    if (cmd_i.out_load) begin
      out_drive_q <= drive_c;
      out_filt_q  <= filt_q;
    end
  end

  assign drive_o          = out_drive_q;
  assign filtered_speed_o = out_filt_q;

endmodule

`default_nettype wire

[src/mlp_ctrl.sv]
// Controller: sequences the datapath steps for one word and runs the handshakes.
`default_nettype none

module mlp_ctrl #(
  parameter int unsigned WINDOW_LEN = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  mlp_pkg::dp_stat_t stat_i,
  output mlp_pkg::dp_cmd_t  cmd_o
);

  import mlp_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MED, ST_F1, ST_F2, ST_F3, ST_ERR, ST_W1, ST_QR, ST_M1, ST_M2, ST_M3,
    ST_W2, ST_INTEG, ST_D1, ST_D2, ST_W3, ST_DERIV, ST_G0, ST_G1, ST_G2, ST_G3, ST_OUT
  } state_e;

  localparam logic [IDX_W-1:0] MED_LAST = IDX_W'(WINDOW_LEN - 1);

  state_e           state_q;
  op_e              op_q;
  logic [IDX_W-1:0] idx_q;
  logic             out_valid_q;
  logic             load, out_load;

  assign in_ready_o = (state_q == ST_IDLE);
  assign load       = in_valid_i && (state_q == ST_IDLE);
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // State, step command and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_NONE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      op_q <= OP_NONE;
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_MED;
            op_q    <= OP_MED;
            idx_q   <= '0;
          end
        end
        ST_MED: begin
          if (idx_q == MED_LAST) begin
            state_q <= ST_F1;
            op_q    <= OP_F1;
          end else begin
            idx_q <= idx_q + 1'b1;
            op_q  <= OP_MED;
          end
        end
        ST_F1: begin
          state_q <= ST_F2;
          op_q    <= OP_F2;
        end
        ST_F2: begin
          state_q <= ST_F3;
          op_q    <= OP_F3;
        end
        ST_F3: begin
          state_q <= ST_ERR;
          op_q    <= OP_ERR;
        end
        ST_ERR: state_q <= ST_W1;
        ST_W1: begin
          if (!stat_i.div_busy) begin
            state_q <= ST_QR;
            op_q    <= OP_QR;
          end
        end
        ST_QR: begin
          state_q <= ST_M1;
          op_q    <= OP_M1;
        end
        ST_M1: begin
          state_q <= ST_M2;
          op_q    <= OP_M2;
        end
        ST_M2: begin
          state_q <= ST_M3;
          op_q    <= OP_M3;
        end
        ST_M3: state_q <= ST_W2;
        ST_W2: begin
          if (!stat_i.div_busy) begin
            state_q <= ST_INTEG;
            op_q    <= OP_INTEG;
          end
        end
        ST_INTEG: begin
          state_q <= ST_D1;
          op_q    <= OP_D1;
        end
        ST_D1: begin
          state_q <= ST_D2;
          op_q    <= OP_D2;
        end
        ST_D2: state_q <= ST_W3;
        ST_W3: begin
          if (!stat_i.div_busy) begin
            state_q <= ST_DERIV;
            op_q    <= OP_DERIV;
          end
        end
        ST_DERIV: begin
          state_q <= ST_G0;
          op_q    <= OP_G0;
          idx_q   <= TERM_ERR;
        end
        ST_G0: begin
          state_q <= ST_G1;
          op_q    <= OP_G1;
        end
        ST_G1: begin
          state_q <= ST_G2;
          op_q    <= OP_G2;
        end
        ST_G2: begin
          state_q <= ST_G3;
          op_q    <= OP_G3;
        end
        ST_G3: begin
          if (idx_q == TERM_DER) begin
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_G0;
            op_q    <= OP_G0;
            idx_q   <= idx_q + 1'b1;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cmd_o.op       = op_q;
  assign cmd_o.idx      = idx_q;
  assign cmd_o.load     = load;
  assign cmd_o.out_load = out_load;

endmodule

`default_nettype wire

[src/median_lowpass_pid_speed_loop_unit.sv]
// Top level of the median, low-pass and PID speed loop.
`default_nettype none

// Each accepted word carries a Q16.16 speed sample and a microsecond timestamp and
// yields one word with the clamped drive and the filtered speed. The block works on
// one word at a time. The time per word is set mostly by three passes through the
// shared divider (splitting dt into seconds, scaling the integral fraction and
// forming the derivative) at two quotient bits per cycle, plus the median rank
// search over the window and the products on the single shared multiplier. A
// finished result sits in the output register, so the next sample is accepted
// while it waits to be taken. The user must write configuration through cfg_we_i,
// cfg_index_i and cfg_data_i only while idle; the block itself does not enforce it.
module median_lowpass_pid_speed_loop_unit #(
  parameter int unsigned WINDOW_LEN = 5
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  mlp_in_if.sink                         in_i,
  mlp_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [mlp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mlp_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import mlp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Step sequencer.
  mlp_ctrl #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Arithmetic and state.
  mlp_dp #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .speed_sample_i  (in_i.speed_sample),
    .timestamp_us_i  (in_i.timestamp_us),
    .drive_o         (out_o.drive),
    .filtered_speed_o(out_o.filtered_speed)
  );

endmodule

`default_nettype wire
